>>> rtl/core/asd_pkg.sv
// Package with the shared types and constants of the ACK suppression decider.
package asd_pkg;

	typedef enum logic [1:0] {
		REQ_PACKET    = 2'd0,
		REQ_FRAME     = 2'd1,
		REQ_IMMEDIATE = 2'd2,
		REQ_ACK_SENT  = 2'd3
	} req_type_t;

	localparam logic CFG_EXT_ENABLED = 1'b0;
	localparam logic CFG_MIN_DELAY   = 1'b1;

	localparam int PN_BITS    = 62;
	localparam int DELAY_BITS = 24;

	localparam logic [PN_BITS-1:0]    DEF_THRESHOLD = 62'd2;
	localparam logic [PN_BITS-1:0]    DEF_DELAY     = 62'd25000;
	localparam logic [DELAY_BITS-1:0] DEF_MIN_DELAY = 24'd25000;
	localparam logic [63:0]           LEGACY_LIMIT  = 64'd2;

	typedef struct packed {
		logic [PN_BITS-1:0] largest_pn;
		logic [PN_BITS-1:0] last_seq;
		logic [PN_BITS-1:0] threshold;
		logic [PN_BITS-1:0] ack_delay;
		logic [PN_BITS-1:0] reorder;
		logic               order_ignored;
		logic               immediate_pending;
	} ack_state_t;

	typedef struct packed {
		logic               ext_enabled;
		logic [DELAY_BITS-1:0] min_delay;
	} ack_cfg_t;

endpackage

>>> rtl/core/ack_suppression_decider.sv
// Top level of the ACK suppression decider with its input, result and state registers.
// Usage: each input transaction carries one event (packet received, frequency update
// frame, immediate-acknowledge request or ACK sent) and yields exactly one result
// transaction with send_ack, frame_ignored and the maximum ACK delay in force
// after the event. Results come out in the order the events went in.
// The event sits in the input register, is decided against the state, and the result is
// registered while the state is updated. Throughput is one event per cycle while the
// receiver takes the results; the next event sees the state left by the previous one. If
// the receiver stalls, the result register holds and one more event waits in the input
// register before ready drops.
// Configuration writes (index 0 enables the extension, index 1 sets the minimum
// ACK delay) are always accepted and are meant to be done while the block is idle.
// Reset clears the counter and frame state, restores a threshold of two and a
// delay of 25000 microseconds, and empties both registers.
module ack_suppression_decider #(
	parameter int COUNT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [asd_pkg::PN_BITS-1:0]         packet_number,
	input  logic                                elicits_ack,
	input  logic [asd_pkg::PN_BITS-1:0]         frame_sequence,
	input  logic [asd_pkg::PN_BITS-1:0]         new_threshold,
	input  logic [asd_pkg::PN_BITS-1:0]         requested_delay,
	input  logic [asd_pkg::PN_BITS-1:0]         new_reorder,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                send_ack,
	output logic                                frame_ignored,
	output logic [asd_pkg::PN_BITS-1:0]         current_delay,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [asd_pkg::DELAY_BITS-1:0]      cfg_data
);

	logic                        valid_s1;
	asd_pkg::req_type_t          req_type_s1;
	logic [asd_pkg::PN_BITS-1:0] packet_number_s1;
	logic                        elicits_ack_s1;
	logic [asd_pkg::PN_BITS-1:0] frame_sequence_s1;
	logic [asd_pkg::PN_BITS-1:0] new_threshold_s1;
	logic [asd_pkg::PN_BITS-1:0] requested_delay_s1;
	logic [asd_pkg::PN_BITS-1:0] new_reorder_s1;

	asd_pkg::ack_cfg_t   cfg_q;
	asd_pkg::ack_state_t state_q;
	asd_pkg::ack_state_t state_next;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_next;
	logic                  send_next;
	logic                  ignored_next;

	logic out_valid_q;
	logic send_q;
	logic ignored_q;
	logic [asd_pkg::PN_BITS-1:0] delay_q;

	logic advance;
	logic in_fire;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1        <= asd_pkg::req_type_t'(req_type);
			packet_number_s1   <= packet_number;
			elicits_ack_s1     <= elicits_ack;
			frame_sequence_s1  <= frame_sequence;
			new_threshold_s1   <= new_threshold;
			requested_delay_s1 <= requested_delay;
			new_reorder_s1     <= new_reorder;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ext_enabled <= 1'b0;
			cfg_q.min_delay   <= asd_pkg::DEF_MIN_DELAY;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				asd_pkg::CFG_EXT_ENABLED: cfg_q.ext_enabled <= cfg_data[0];
				asd_pkg::CFG_MIN_DELAY:   cfg_q.min_delay   <= cfg_data;
				default: ;
			endcase
		end
	end

	asd_decide #(
		.COUNT_BITS(COUNT_BITS)
	) u_decide (
		.req_type       (req_type_s1),
		.packet_number  (packet_number_s1),
		.elicits_ack    (elicits_ack_s1),
		.frame_sequence (frame_sequence_s1),
		.new_threshold  (new_threshold_s1),
		.requested_delay(requested_delay_s1),
		.new_reorder    (new_reorder_s1),
		.cfg            (cfg_q),
		.state          (state_q),
		.count          (count_q),
		.state_next     (state_next),
		.count_next     (count_next),
		.send_ack       (send_next),
		.frame_ignored  (ignored_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.largest_pn        <= '0;
			state_q.last_seq          <= '0;
			state_q.threshold         <= asd_pkg::DEF_THRESHOLD;
			state_q.ack_delay         <= asd_pkg::DEF_DELAY;
			state_q.reorder           <= '0;
			state_q.order_ignored     <= 1'b0;
			state_q.immediate_pending <= 1'b0;
			count_q                   <= '0;
		end else if (advance) begin
			state_q <= state_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			send_q    <= send_next;
			ignored_q <= ignored_next;
			delay_q   <= state_next.ack_delay;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_ack      = send_q;
	assign frame_ignored = ignored_q;
	assign current_delay = delay_q;

endmodule

>>> rtl/core/asd_decide.sv
// Combinational ACK decision and next-state logic for one event.
module asd_decide #(
	parameter int COUNT_BITS = 32
) (
	input  asd_pkg::req_type_t          req_type,
	input  logic [asd_pkg::PN_BITS-1:0] packet_number,
	input  logic                        elicits_ack,
	input  logic [asd_pkg::PN_BITS-1:0] frame_sequence,
	input  logic [asd_pkg::PN_BITS-1:0] new_threshold,
	input  logic [asd_pkg::PN_BITS-1:0] requested_delay,
	input  logic [asd_pkg::PN_BITS-1:0] new_reorder,
	input  asd_pkg::ack_cfg_t           cfg,
	input  asd_pkg::ack_state_t         state,
	input  logic [COUNT_BITS-1:0]       count,
	output asd_pkg::ack_state_t         state_next,
	output logic [COUNT_BITS-1:0]       count_next,
	output logic                        send_ack,
	output logic                        frame_ignored
);

	logic [COUNT_BITS-1:0]       count_inc;
	logic [63:0]                 count_ext;
	logic [asd_pkg::PN_BITS-1:0] floor_delay;
	logic [asd_pkg::PN_BITS-1:0] gap;

	always_comb begin
		count_inc   = (&count) ? count : count + COUNT_BITS'(1);
		count_ext   = 64'(count_inc);
		floor_delay = asd_pkg::PN_BITS'(cfg.min_delay);
		gap         = state.largest_pn - packet_number;
	end

	always_comb begin
		state_next    = state;
		count_next    = count;
		send_ack      = 1'b0;
		frame_ignored = 1'b0;
		case (req_type)
			asd_pkg::REQ_PACKET: begin
				if (elicits_ack) begin
					if (!cfg.ext_enabled) begin
						count_next = count_inc;
						send_ack   = count_ext >= asd_pkg::LEGACY_LIMIT;
					end else if (state.immediate_pending) begin
						state_next.immediate_pending = 1'b0;
						send_ack                     = 1'b1;
					end else begin
						count_next = count_inc;
						if (count_ext >= {2'b00, state.threshold}) begin
							send_ack = 1'b1;
						end else if (!state.order_ignored && state.reorder != '0 &&
							packet_number < state.largest_pn && gap >= state.reorder) begin
							send_ack = 1'b1;
						end else if (packet_number > state.largest_pn) begin
							state_next.largest_pn = packet_number;
						end
					end
				end
			end
			asd_pkg::REQ_FRAME: begin
				if ((frame_sequence <= state.last_seq && state.last_seq != '0) ||
					new_threshold == '0) begin
					frame_ignored = 1'b1;
				end else begin
					state_next.last_seq      = frame_sequence;
					state_next.threshold     = new_threshold;
					state_next.ack_delay     = (requested_delay > floor_delay) ?
						requested_delay : floor_delay;
					state_next.order_ignored = new_reorder == '0;
					state_next.reorder       = new_reorder;
				end
			end
			asd_pkg::REQ_IMMEDIATE: begin
				state_next.immediate_pending = 1'b1;
			end
			default: begin
				count_next = '0;
			end
		endcase
	end

endmodule

>>> tb/sv/ack_decision_checker.sv
// Checker that predicts the ACK decision for every event and compares it with the results.
module ack_decision_checker #(
	parameter int COUNT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [asd_pkg::PN_BITS-1:0]    packet_number,
	input  logic                           elicits_ack,
	input  logic [asd_pkg::PN_BITS-1:0]    frame_sequence,
	input  logic [asd_pkg::PN_BITS-1:0]    new_threshold,
	input  logic [asd_pkg::PN_BITS-1:0]    requested_delay,
	input  logic [asd_pkg::PN_BITS-1:0]    new_reorder,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           send_ack,
	input  logic                           frame_ignored,
	input  logic [asd_pkg::PN_BITS-1:0]    current_delay,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [asd_pkg::DELAY_BITS-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);

	typedef struct packed {
		logic                        ack;
		logic                        dropped;
		logic [asd_pkg::PN_BITS-1:0] delay;
	} decision_t;

	decision_t                      decisions_due[$];
	logic                           ext_on;
	logic [asd_pkg::DELAY_BITS-1:0] min_delay;
	logic [COUNT_BITS-1:0]          elicit_cnt;
	logic [asd_pkg::PN_BITS-1:0]    largest_pn;
	logic [asd_pkg::PN_BITS-1:0]    last_seq;
	logic [asd_pkg::PN_BITS-1:0]    threshold;
	logic [asd_pkg::PN_BITS-1:0]    cur_delay;
	logic [asd_pkg::PN_BITS-1:0]    reorder_limit;
	logic                           order_ign;
	logic                           imm_pending;
	int                             miss_total;

	function automatic decision_t predict_decision();
		decision_t d;
		d = '0;
		case (asd_pkg::req_type_t'(req_type))
			asd_pkg::REQ_PACKET: begin
				if (elicits_ack) begin
					if (!ext_on) begin
						if (elicit_cnt != '1) elicit_cnt = elicit_cnt + COUNT_BITS'(1);
						d.ack = 64'(elicit_cnt) >= asd_pkg::LEGACY_LIMIT;
					end else if (imm_pending) begin
						imm_pending = 1'b0;
						d.ack       = 1'b1;
					end else begin
						if (elicit_cnt != '1) elicit_cnt = elicit_cnt + COUNT_BITS'(1);
						if (64'(elicit_cnt) >= 64'(threshold))
							d.ack = 1'b1;
						else if (!order_ign && reorder_limit != '0 && packet_number < largest_pn
								&& largest_pn - packet_number >= reorder_limit)
							d.ack = 1'b1;
						else if (packet_number > largest_pn)
							largest_pn = packet_number;
					end
				end
			end
			asd_pkg::REQ_FRAME: begin
				if ((frame_sequence <= last_seq && last_seq != '0) || new_threshold == '0) begin
					d.dropped = 1'b1;
				end else begin
					last_seq      = frame_sequence;
					threshold     = new_threshold;
					cur_delay     = (requested_delay > asd_pkg::PN_BITS'(min_delay)) ?
							requested_delay : asd_pkg::PN_BITS'(min_delay);
					order_ign     = new_reorder == '0;
					reorder_limit = new_reorder;
				end
			end
			asd_pkg::REQ_IMMEDIATE: imm_pending = 1'b1;
			asd_pkg::REQ_ACK_SENT:  elicit_cnt = '0;
		endcase
		d.delay = cur_delay;
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decision_t want;
		if (!arst_n) begin
			ext_on        = 1'b0;
			min_delay     = asd_pkg::DEF_MIN_DELAY;
			elicit_cnt    = '0;
			largest_pn    = '0;
			last_seq      = '0;
			threshold     = asd_pkg::DEF_THRESHOLD;
			cur_delay     = asd_pkg::DEF_DELAY;
			reorder_limit = '0;
			order_ign     = 1'b0;
			imm_pending   = 1'b0;
			miss_total    = 0;
			decisions_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (decisions_due.size() == 0) begin
					$display("%0t: unexpected result send_ack=%0b frame_ignored=%0b current_delay=%0d",
							$time, send_ack, frame_ignored, current_delay);
					miss_total++;
				end else begin
					want = decisions_due.pop_front();
					if (send_ack !== want.ack) begin
						$display("%0t: send_ack expected %0b, got %0b", $time, want.ack, send_ack);
						miss_total++;
					end
					if (frame_ignored !== want.dropped) begin
						$display("%0t: frame_ignored expected %0b, got %0b",
								$time, want.dropped, frame_ignored);
						miss_total++;
					end
					if (current_delay !== want.delay) begin
						$display("%0t: current_delay expected %0d, got %0d",
								$time, want.delay, current_delay);
						miss_total++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == asd_pkg::CFG_EXT_ENABLED) ext_on = cfg_data[0];
				else min_delay = cfg_data;
			end
			if (in_valid && in_ready) decisions_due.push_back(predict_decision());
		end
		mismatches  <= miss_total;
		outstanding <= decisions_due.size();
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench: clock, reset, event stimulus, register writes and the verdict.
module testbench;

	typedef struct packed {
		asd_pkg::req_type_t          kind;
		logic [asd_pkg::PN_BITS-1:0] pn;
		logic                        elicit;
		logic [asd_pkg::PN_BITS-1:0] seq;
		logic [asd_pkg::PN_BITS-1:0] thr;
		logic [asd_pkg::PN_BITS-1:0] dly;
		logic [asd_pkg::PN_BITS-1:0] reo;
	} ack_event_t;

	localparam logic [asd_pkg::PN_BITS-1:0] PN_MAX       = '1;
	localparam int                          PHASES       = 5;
	localparam int                          STALL_CYCLES = 80;

	logic                           clk             = 1'b0;
	logic                           arst_n          = 1'b0;
	logic                           in_valid        = 1'b0;
	logic                           in_ready;
	logic [1:0]                     req_type        = asd_pkg::REQ_PACKET;
	logic [asd_pkg::PN_BITS-1:0]    packet_number   = '0;
	logic                           elicits_ack     = 1'b0;
	logic [asd_pkg::PN_BITS-1:0]    frame_sequence  = '0;
	logic [asd_pkg::PN_BITS-1:0]    new_threshold   = '0;
	logic [asd_pkg::PN_BITS-1:0]    requested_delay = '0;
	logic [asd_pkg::PN_BITS-1:0]    new_reorder     = '0;
	logic                           out_valid;
	logic                           out_ready       = 1'b0;
	logic                           send_ack;
	logic                           frame_ignored;
	logic [asd_pkg::PN_BITS-1:0]    current_delay;
	logic                           cfg_valid       = 1'b0;
	logic                           cfg_ready;
	logic                           cfg_index       = asd_pkg::CFG_EXT_ENABLED;
	logic [asd_pkg::DELAY_BITS-1:0] cfg_data        = '0;
	int                             mismatches;
	int                             outstanding;

	logic                           gaps_on  = 1'b1;
	logic                           hold_req = 1'b0;
	logic [asd_pkg::PN_BITS-1:0]    pn_base  = 62'd1000;
	logic [asd_pkg::PN_BITS-1:0]    seq_base = 62'd10;
	int                             kind_count[4];
	int                             settings = 0;

	logic                           ph_ext[PHASES]   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	int                             ph_items[PHASES] = '{100, 60, 100, 80, 60};
	logic [asd_pkg::DELAY_BITS-1:0] ph_min[3]        = '{24'd25000, 24'd16383000, 24'd1};

	ack_suppression_decider u_dut (.*);

	ack_decision_checker u_checker (.*);

	always #6 clk = ~clk;

	function automatic logic [asd_pkg::PN_BITS-1:0] rand62();
		return asd_pkg::PN_BITS'({$urandom(), $urandom()});
	endfunction

	function automatic logic [asd_pkg::PN_BITS-1:0] small62(input int unsigned lo,
			input int unsigned hi);
		return asd_pkg::PN_BITS'($urandom_range(lo, hi));
	endfunction

	function automatic ack_event_t build_event(input asd_pkg::req_type_t k,
			input logic [asd_pkg::PN_BITS-1:0] pn, input logic el,
			input logic [asd_pkg::PN_BITS-1:0] seq, input logic [asd_pkg::PN_BITS-1:0] thr,
			input logic [asd_pkg::PN_BITS-1:0] dly, input logic [asd_pkg::PN_BITS-1:0] reo);
		ack_event_t e;
		e.kind   = k;
		e.pn     = pn;
		e.elicit = el;
		e.seq    = seq;
		e.thr    = thr;
		e.dly    = dly;
		e.reo    = reo;
		return e;
	endfunction

	// Mostly in-order packets and fresh frames, with reordering, stale and invalid frames mixed in.
	function automatic ack_event_t random_event();
		ack_event_t  e;
		int unsigned pick;
		int unsigned sel;
		e = build_event(asd_pkg::REQ_ACK_SENT, rand62(), 1'($urandom()), rand62(), rand62(),
				rand62(), rand62());
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			e.kind   = asd_pkg::REQ_PACKET;
			e.elicit = $urandom_range(0, 99) < 85;
			sel      = $urandom_range(0, 9);
			if (sel < 7) begin
				pn_base = pn_base + small62(1, 3);
				e.pn    = pn_base;
			end else if (sel < 9) begin
				e.pn = pn_base - small62(0, 12);
			end else begin
				e.elicit = 1'b0;
			end
		end else if (pick < 72) begin
			e.kind = asd_pkg::REQ_ACK_SENT;
		end else if (pick < 80) begin
			e.kind = asd_pkg::REQ_IMMEDIATE;
		end else begin
			e.kind = asd_pkg::REQ_FRAME;
			if (pick < 94) begin
				seq_base = seq_base + small62(1, 2);
				e.seq    = seq_base;
				if ($urandom_range(0, 7) != 0) e.thr = small62(1, 6);
				sel = $urandom_range(0, 3);
				if (sel == 0) e.dly = small62(0, 40000);
				else if (sel == 1) e.dly = small62(0, 20000000);
				else if (sel == 2) e.dly = '0;
				sel = $urandom_range(0, 7);
				if (sel < 2) e.reo = '0;
				else if (sel < 7) e.reo = small62(1, 10);
			end else if (pick < 97) begin
				e.seq = seq_base - small62(0, 3);
			end else begin
				e.thr = '0;
			end
		end
		return e;
	endfunction

	task automatic send_event(input ack_event_t e);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		req_type        <= e.kind;
		packet_number   <= e.pn;
		elicits_ack     <= e.elicit;
		frame_sequence  <= e.seq;
		new_threshold   <= e.thr;
		requested_delay <= e.dly;
		new_reorder     <= e.reo;
		kind_count[e.kind]++;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic configure(input logic ext, input logic [asd_pkg::DELAY_BITS-1:0] dly);
		cfg_valid <= 1'b1;
		cfg_index <= asd_pkg::CFG_EXT_ENABLED;
		cfg_data  <= {23'($urandom()), ext};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= asd_pkg::CFG_MIN_DELAY;
		cfg_data  <= dly;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				out_ready <= !gaps_on || $urandom_range(0, 99) >= 29;
			end
		end
	end

	initial begin
		logic [asd_pkg::DELAY_BITS-1:0] dly;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default setting after reset: eliciting packets are acknowledged from the second one on until an ACK is sent.
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd5, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd6, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd7, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_IMMEDIATE, '0, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd8, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_ACK_SENT, '0, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, '0, 62'd3, '0, 62'd5));
		drain();

		configure(1'b1, 24'd1000);
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd9, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, '0, 62'd3, 62'd500, 62'd4));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, 62'd1, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, PN_MAX, '0, PN_MAX, PN_MAX));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, 62'd1, 62'd3, PN_MAX, 62'd4));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, 62'd1, 62'd5, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd20, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd15, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd17, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_ACK_SENT, '0, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_FRAME, '0, 1'b0, 62'd2, 62'd1, 62'd30000, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, PN_MAX, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, '0, 1'b1, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, PN_MAX, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_IMMEDIATE, '0, 1'b0, '0, '0, '0, '0));
		send_event(build_event(asd_pkg::REQ_PACKET, 62'd3, 1'b1, '0, '0, '0, '0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			gaps_on <= p != 0;
			if (p == 3) begin
				pn_base  = PN_MAX - 62'd100000;
				seq_base = PN_MAX - 62'd1000;
			end
			dly = (p < 3) ? ph_min[p] : asd_pkg::DELAY_BITS'($urandom_range(1, 16383000));
			configure(ph_ext[p], dly);
			if (p == 2) hold_req <= 1'b1;
			repeat (ph_items[p]) send_event(random_event());
			drain();
		end

		$display("Sent %0d events: %0d packets, %0d frequency updates, %0d immediate requests, %0d ACK sent.",
				kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
				kind_count[asd_pkg::REQ_PACKET], kind_count[asd_pkg::REQ_FRAME],
				kind_count[asd_pkg::REQ_IMMEDIATE], kind_count[asd_pkg::REQ_ACK_SENT]);
		$display("Went through %0d register settings with random stalls and one long output stall.",
				settings);
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
